### hw/rtl/knn_pkg.sv
// Package for the k-nearest-neighbour search block.
// Word types, sizes and register indexes; no dependencies.
package knn_pkg;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned MaxDim    = 64;
  localparam int unsigned MaxK      = 16;

  localparam int unsigned RowW  = 10;
  localparam int unsigned DimW  = 6;
  localparam int unsigned KW    = 4;
  localparam int unsigned DistW = 38;
  localparam int unsigned AddrW = RowW + DimW;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegPointCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDimension  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNeighbors  = 2'd2;

  localparam logic [DistW-1:0] DistOnes = {DistW{1'b1}};

  typedef struct packed {
    logic              req_type;
    logic [RowW-1:0]   row_index;
    logic [DimW-1:0]   dim_index;
    logic signed [15:0] value;
    logic              skip_enable;
    logic [RowW-1:0]   skip_row;
    logic              query_last;
  } in_word_t;

  typedef struct packed {
    logic [KW-1:0]    rank;
    logic [RowW-1:0]  neighbor_index;
    logic [DistW-1:0] sq_distance;
    logic             all_zero;
    logic             last;
  } out_word_t;

  // Candidate offered to the sorted list.
  typedef struct packed {
    logic             valid;
    logic [DistW-1:0] distance;
    logic [RowW-1:0]  row;
  } cand_t;

endpackage

### hw/rtl/knn_best_list.sv
// Sorted list of the K best candidates, one insertion per cycle.
// Depends on knn_pkg.
module knn_best_list (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  knn_pkg::cand_t            cand_i,
  input  logic [knn_pkg::KW-1:0]    rd_sel_i,
  output logic [knn_pkg::DistW-1:0] rd_dist_o,
  output logic [knn_pkg::RowW-1:0]  rd_row_o
);
  import knn_pkg::*;

  logic [DistW-1:0] dist_q [MaxK];
  logic [RowW-1:0]  row_q  [MaxK];
  logic [MaxK-1:0]  less;

  // Entries beyond K fall off the end, so only K entries matter.
  // Strict compare keeps the earlier (lower) row on a tie.
  always_comb begin
    for (int i = 0; i < MaxK; i++) less[i] = cand_i.distance < dist_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxK; i++) begin
        dist_q[i] <= DistOnes;
        row_q[i]  <= '0;
      end
    end else if (clear_i) begin
      for (int i = 0; i < MaxK; i++) begin
        dist_q[i] <= DistOnes;
        row_q[i]  <= '0;
      end
    end else if (cand_i.valid) begin
      if (less[0]) begin
        dist_q[0] <= cand_i.distance;
        row_q[0]  <= cand_i.row;
      end
      for (int i = 1; i < MaxK; i++) begin
        if (less[i]) begin
          if (!less[i-1]) begin
            dist_q[i] <= cand_i.distance;
            row_q[i]  <= cand_i.row;
          end else begin
            dist_q[i] <= dist_q[i-1];
            row_q[i]  <= row_q[i-1];
          end
        end
      end
    end
  end

  assign rd_dist_o = dist_q[rd_sel_i];
  assign rd_row_o  = row_q[rd_sel_i];

endmodule

### hw/rtl/k_nearest_neighbor_search.sv
// Top level of the k-nearest-neighbour search block.
// Depends on knn_pkg and knn_best_list.
//
// Load words (req_type 0) write one Q8.8 coordinate into the 64K-entry point
// store and query words (req_type 1) one coordinate of the query vector. A
// query word with query_last set starts a brute-force scan of rows
// 0..point_count-1 (skip_row left out when skip_enable is set): one shared
// subtract-square-accumulate unit takes one coordinate per cycle from the
// store's single read port while a row is being read. After the last row the
// pipeline drains and the K list entries are scanned for all-zero, and then
// the first result word is offered. in_ready_o stays low from the last query
// word until the last of the K result words has been accepted, one per cycle
// when not stalled.
// Each finished row distance is inserted into a sorted list of the K best
// (ties go to the lower row). The K results then leave in ascending order,
// one per accepted output word; all_zero is set when every reported
// distance is zero. Unfilled places report all-ones distance and row 0.
// With dimension zero every distance is zero.
// There is no clearing pass: store entries read before being written give
// undefined data.
module k_nearest_neighbor_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [knn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [knn_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  knn_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output knn_pkg::out_word_t            out_data_o
);
  import knn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_MAC, S_FLAG, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [10:0] np_q;
  logic [6:0]  nd_q;
  logic [4:0]  nk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= 11'd1024;
      nd_q <= 7'd64;
      nk_q <= 5'd4;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPointCount: np_q <= cfg_data_i;
        RegDimension:  nd_q <= cfg_data_i[6:0];
        RegNeighbors:  nk_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // saturated working limits
  logic [10:0] np;
  logic [6:0]  nd;
  logic [4:0]  nk;
  assign np = (np_q > 11'd1024) ? 11'd1024 : np_q;
  assign nd = (nd_q > 7'd64) ? 7'd64 : nd_q;
  assign nk = (nk_q > 5'd16) ? 5'd16 : ((nk_q == 5'd0) ? 5'd1 : nk_q);

  // memories
  logic [15:0] pstore [MaxPoints*MaxDim];
  logic [15:0] qvec   [MaxDim];
  logic [15:0] p_rd_q, q_rd_q;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // scan counters
  logic [10:0] row_q;
  logic [6:0]  dim_q;
  logic        skip_en_q;
  logic [RowW-1:0] skip_row_q;
  logic        rd_vld_q;
  logic [RowW-1:0] rd_row_q;
  logic        rd_lastd_q;

  logic [AddrW-1:0] rd_addr;
  assign rd_addr = {row_q[RowW-1:0], dim_q[DimW-1:0]};

  always_ff @(posedge clk_i) begin
    if (in_acc && !in_data_i.req_type)
      pstore[{in_data_i.row_index, in_data_i.dim_index}] <= in_data_i.value;
    if (in_acc && in_data_i.req_type)
      qvec[in_data_i.dim_index] <= in_data_i.value;
    p_rd_q <= pstore[rd_addr];
    q_rd_q <= qvec[dim_q[DimW-1:0]];
  end

  // shared MAC: one coordinate per cycle
  logic signed [16:0] diff;
  logic [33:0]        sq_q;
  logic               sq_vld_q, sq_last_q;
  logic [RowW-1:0]    sq_row_q;
  logic [DistW-1:0]   acc_q;
  cand_t              cand;

  assign diff = 17'(signed'(p_rd_q)) - 17'(signed'(q_rd_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= 1'b0;
      sq_last_q <= 1'b0;
    end else begin
      sq_vld_q  <= rd_vld_q;
      sq_last_q <= rd_lastd_q;
    end
  end

  // dimension zero: the single coordinate still stepped through is masked
  always_ff @(posedge clk_i) begin
    sq_q     <= (nd == 7'd0) ? '0 : 34'(diff * diff);
    sq_row_q <= rd_row_q;
  end

  logic [DistW-1:0] acc_sum;
  assign acc_sum = acc_q + DistW'(sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (sq_vld_q) begin
      acc_q <= sq_last_q ? '0 : acc_sum;
    end
  end

  assign cand.valid    = sq_vld_q && sq_last_q;
  assign cand.distance = acc_sum;
  assign cand.row      = sq_row_q;

  // sorted list
  logic             clear_list;
  logic [KW-1:0]    sel_q;
  logic [DistW-1:0] sel_dist;
  logic [RowW-1:0]  sel_row;

  assign clear_list = in_acc && in_data_i.req_type && in_data_i.query_last;

  knn_best_list u_list (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (clear_list),
    .cand_i   (cand),
    .rd_sel_i (sel_q),
    .rd_dist_o(sel_dist),
    .rd_row_o (sel_row)
  );

  logic       allz_q;
  logic [2:0] drain_q;
  logic       out_vld_q;
  logic       skip_now;
  assign skip_now = skip_en_q && (row_q[RowW-1:0] == skip_row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      row_q      <= '0;
      dim_q      <= '0;
      skip_en_q  <= 1'b0;
      skip_row_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_row_q   <= '0;
      rd_lastd_q <= 1'b0;
      sel_q      <= '0;
      allz_q     <= 1'b0;
      drain_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_vld_q   <= 1'b0;
      rd_lastd_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (clear_list) begin
            skip_en_q  <= in_data_i.skip_enable;
            skip_row_q <= in_data_i.skip_row;
            row_q      <= '0;
            dim_q      <= '0;
            state_q    <= S_ROW;
          end
        end
        S_ROW: begin
          // pick next row or finish
          dim_q <= '0;
          if (row_q >= np) begin
            drain_q <= 3'd4;
            state_q <= S_FLAG;
          end else if (skip_now) begin
            row_q <= row_q + 11'd1;
          end else begin
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          rd_vld_q   <= 1'b1;
          rd_row_q   <= row_q[RowW-1:0];
          rd_lastd_q <= (dim_q + 7'd1 >= nd);
          if (dim_q + 7'd1 >= nd) begin
            row_q   <= row_q + 11'd1;
            state_q <= S_ROW;
          end
          dim_q <= dim_q + 7'd1;
        end
        S_FLAG: begin
          // let the pipeline drain, then scan list for all-zero
          if (drain_q != '0) begin
            drain_q <= drain_q - 3'd1;
            sel_q   <= '0;
            allz_q  <= 1'b1;
          end else begin
            if (sel_dist != '0) allz_q <= 1'b0;
            if (5'(sel_q) + 5'd1 >= nk) begin
              sel_q     <= '0;
              out_vld_q <= 1'b1;
              state_q   <= S_OUT;
            end else begin
              sel_q <= sel_q + 4'd1;
            end
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            if (5'(sel_q) + 5'd1 >= nk) begin
              out_vld_q <= 1'b0;
              sel_q     <= '0;
              state_q   <= S_IDLE;
            end else begin
              sel_q <= sel_q + 4'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o               = out_vld_q;
  assign out_data_o.rank           = sel_q;
  assign out_data_o.neighbor_index = sel_row;
  assign out_data_o.sq_distance    = sel_dist;
  assign out_data_o.all_zero       = allz_q;
  assign out_data_o.last           = (5'(sel_q) + 5'd1 >= nk);

endmodule
